// File: rtl/ncrb_pkg.sv
// Shared constants and helpers for the NVMe controller register block.
// Holds the BAR0 register map, CAP/VS constants and the byte-lane merge functions.
// No dependencies.
`timescale 1ns / 1ps

package ncrb_pkg;

  localparam int unsigned MAX_QUEUE_ENTRIES = 256;

  localparam logic [11:0] OFS_CAP   = 12'h000;
  localparam logic [11:0] OFS_VS    = 12'h008;
  localparam logic [11:0] OFS_INTMS = 12'h00c;
  localparam logic [11:0] OFS_INTMC = 12'h010;
  localparam logic [11:0] OFS_CC    = 12'h014;
  localparam logic [11:0] OFS_CSTS  = 12'h01c;
  localparam logic [11:0] OFS_AQA   = 12'h024;
  localparam logic [11:0] OFS_ASQ   = 12'h028;
  localparam logic [11:0] OFS_ACQ   = 12'h030;

  localparam logic [23:0] OFS_DB = 24'h001000;

  localparam logic [15:0] CAP_MQES = 16'((MAX_QUEUE_ENTRIES - 1) & 16'hffff);
  localparam logic [63:0] CAP_CONST = {48'h0, CAP_MQES} | (64'd1 << 16) | (64'd10 << 24)
                                      | (64'd1 << 37);
  localparam logic [63:0] VS_CONST  = 64'h0000_0000_0001_0300;

  localparam logic [3:0] ST_RDY       = 4'b0001;
  localparam logic [3:0] ST_CFS       = 4'b0010;
  localparam logic [3:0] ST_SHST_MASK = 4'b1100;
  localparam logic [3:0] ST_SHST_DONE = 4'b1000;

  localparam logic [1:0] SZ_8B = 2'd3;

  localparam logic [1:0] SHN_NONE   = 2'd0;
  localparam logic [1:0] SHN_NORMAL = 2'd1;

  // Mask covering the bytes of an access of the given size, unshifted
  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    logic [63:0] m;
    case (sz)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] lane_merge(input logic [63:0] old_val,
                                             input logic [2:0]  boff,
                                             input logic [1:0]  sz,
                                             input logic [63:0] data);
    logic [63:0] m;
    logic [5:0]  sh;
    sh = {boff, 3'b000};
    m  = size_mask(sz) << sh;
    if (sz == SZ_8B) begin
      return data;
    end
    return (old_val & ~m) | ((data << sh) & m);
  endfunction

  // CSS, MPS, IOSQES and IOCQES acceptable for enable
  function automatic logic cc_valid(input logic [31:0] cc);
    return (cc[6:4] == 3'd0) && (cc[10:7] == 4'd0) &&
           (cc[19:16] == 4'd6) && (cc[23:20] == 4'd4);
  endfunction

endpackage

// File: rtl/nvme_controller_register_block_unit.sv
// An access passes the input register, then the result register, to the result port.
// Throughput: one access per cycle while out_ready is high; the single decode/merge
// stage between the input and result registers sets this and never stalls on its own.
// Reset (rst, synchronous): INTMS, CC, CSTS, AQA, ASQ, ACQ and the storage-ready flag
// clear to zero and both pipeline stages empty.
// Depends on ncrb_pkg.
`timescale 1ns / 1ps

module nvme_controller_register_block_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [23:0] offset,
  input  logic [1:0]  size_code,
  input  logic [63:0] write_data,
  input  logic        admin_queue_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_data,
  output logic        doorbell_valid,
  output logic        doorbell_is_completion,
  output logic [15:0] doorbell_queue,
  output logic [31:0] doorbell_value,
  output logic        enable_attempt,
  output logic        queue_reset,
  output logic        controller_ready,
  output logic        controller_fatal,
  output logic [31:0] interrupt_mask,
  output logic        unmask_event
);
  import ncrb_pkg::*;

  // architectural state
  logic        store_ready;
  logic [31:0] interrupt_mask_reg;
  logic [31:0] controller_config_reg;
  logic [3:0]  controller_status_reg;
  logic [31:0] admin_queue_attrs_reg;
  logic [63:0] admin_sq_base_reg;
  logic [63:0] admin_cq_base_reg;

  // input register
  logic        s1_valid;
  logic        s1_op;
  logic [23:0] s1_offset;
  logic [1:0]  s1_size;
  logic [63:0] s1_data;
  logic        s1_aq_ok;

  logic s1_adv;
  logic s1_fire;

  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  // decode and merge
  logic        is_db;
  logic [23:0] db_rel;
  logic [11:0] a8;
  logic        use_a8;
  logic [11:0] base;
  logic [2:0]  boff;
  logic [63:0] reg_val;
  logic [63:0] rd;
  logic [63:0] merged;
  logic [31:0] cc_new;
  logic        pre_ok;
  logic        skip_shn;

  logic        db_valid_next;
  logic        db_cq_next;
  logic [15:0] db_q_next;
  logic [31:0] db_val_next;
  logic        enable_att_next;
  logic        qreset_next;
  logic        unmask_next;

  logic [31:0] interrupt_mask_next;
  logic [31:0] controller_config_next;
  logic [3:0]  controller_status_next;
  logic [31:0] admin_queue_attrs_next;
  logic [63:0] admin_sq_base_next;
  logic [63:0] admin_cq_base_next;

  always_comb begin
    is_db  = (s1_offset[23:12] != 12'd0);
    db_rel = s1_offset - OFS_DB;
    a8     = {s1_offset[11:3], 3'b000};
    use_a8 = (a8 == OFS_CAP) || (a8 == OFS_ASQ) || (a8 == OFS_ACQ);
    base   = use_a8 ? a8 : {s1_offset[11:2], 2'b00};
    boff   = use_a8 ? s1_offset[2:0] : {1'b0, s1_offset[1:0]};

    case (base)
      OFS_CAP:   reg_val = CAP_CONST;
      OFS_VS:    reg_val = VS_CONST;
      OFS_INTMS: reg_val = {32'h0, interrupt_mask_reg};
      OFS_INTMC: reg_val = {32'h0, interrupt_mask_reg};
      OFS_CC:    reg_val = {32'h0, controller_config_reg};
      OFS_CSTS:  reg_val = {60'h0, controller_status_reg};
      OFS_AQA:   reg_val = {32'h0, admin_queue_attrs_reg};
      OFS_ASQ:   reg_val = admin_sq_base_reg;
      OFS_ACQ:   reg_val = admin_cq_base_reg;
      default:   reg_val = 64'h0;
    endcase

    // source operand chosen per target so one merger serves every register
    case (base)
      OFS_ASQ:   merged = lane_merge(admin_sq_base_reg, boff, s1_size, s1_data);
      OFS_ACQ:   merged = lane_merge(admin_cq_base_reg, boff, s1_size, s1_data);
      OFS_AQA:   merged = lane_merge({32'h0, admin_queue_attrs_reg}, boff, s1_size, s1_data);
      OFS_CC:    merged = lane_merge({32'h0, controller_config_reg}, boff, s1_size, s1_data);
      default:   merged = lane_merge(64'h0, boff, s1_size, s1_data);
    endcase

    if (s1_size == SZ_8B) begin
      rd = reg_val;
    end else begin
      rd = (reg_val >> {boff, 3'b000}) & size_mask(s1_size);
    end

    db_valid_next   = 1'b0;
    db_cq_next      = 1'b0;
    db_q_next       = 16'h0;
    db_val_next     = 32'h0;
    enable_att_next = 1'b0;
    qreset_next     = 1'b0;
    unmask_next     = 1'b0;
    cc_new          = merged[31:0];
    pre_ok          = store_ready && cc_valid(cc_new);
    skip_shn        = 1'b0;

    interrupt_mask_next    = interrupt_mask_reg;
    controller_config_next = controller_config_reg;
    controller_status_next = controller_status_reg;
    admin_queue_attrs_next = admin_queue_attrs_reg;
    admin_sq_base_next     = admin_sq_base_reg;
    admin_cq_base_next     = admin_cq_base_reg;

    if (is_db) begin
      rd = 64'h0;
      if (s1_op && controller_status_reg[0]) begin
        db_valid_next = 1'b1;
        db_cq_next    = db_rel[2];
        db_q_next     = db_rel[18:3];
        db_val_next   = s1_data[31:0];
      end
    end else if (s1_op) begin
      rd = 64'h0;
      case (base)
        OFS_ASQ:   admin_sq_base_next = merged;
        OFS_ACQ:   admin_cq_base_next = merged;
        OFS_INTMS: interrupt_mask_next = interrupt_mask_reg | merged[31:0];
        OFS_INTMC: begin
          interrupt_mask_next = interrupt_mask_reg & ~merged[31:0];
          unmask_next         = 1'b1;
        end
        OFS_AQA:   admin_queue_attrs_next = merged[31:0];
        OFS_CC: begin
          controller_config_next = cc_new;
          if (cc_new[0] && !controller_config_reg[0]) begin
            enable_att_next = pre_ok;
            if (!pre_ok || !s1_aq_ok) begin
              controller_status_next = ST_CFS;
              skip_shn               = 1'b1;
            end else begin
              controller_status_next = ST_RDY;
            end
          end else if (!cc_new[0] && controller_config_reg[0]) begin
            qreset_next            = 1'b1;
            controller_status_next = 4'h0;
          end
          if (!skip_shn) begin
            if (cc_new[15:14] == SHN_NORMAL) begin
              controller_status_next = (controller_status_next & ~ST_SHST_MASK) | ST_SHST_DONE;
            end else if (cc_new[15:14] == SHN_NONE) begin
              controller_status_next = controller_status_next & ~ST_SHST_MASK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_ready           <= 1'b0;
      interrupt_mask_reg    <= '0;
      controller_config_reg <= '0;
      controller_status_reg <= '0;
      admin_queue_attrs_reg <= '0;
      admin_sq_base_reg     <= '0;
      admin_cq_base_reg     <= '0;
      s1_valid              <= 1'b0;
      out_valid             <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        store_ready <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        interrupt_mask_reg    <= interrupt_mask_next;
        controller_config_reg <= controller_config_next;
        controller_status_reg <= controller_status_next;
        admin_queue_attrs_reg <= admin_queue_attrs_next;
        admin_sq_base_reg     <= admin_sq_base_next;
        admin_cq_base_reg     <= admin_cq_base_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= op;
      s1_offset <= offset;
      s1_size   <= size_code;
      s1_data   <= write_data;
      s1_aq_ok  <= admin_queue_ok;
    end
    if (s1_fire) begin
      read_data              <= rd;
      doorbell_valid         <= db_valid_next;
      doorbell_is_completion <= db_cq_next;
      doorbell_queue         <= db_q_next;
      doorbell_value         <= db_val_next;
      enable_attempt         <= enable_att_next;
      queue_reset            <= qreset_next;
      controller_ready       <= controller_status_next[0];
      controller_fatal       <= controller_status_next[1];
      interrupt_mask         <= interrupt_mask_next;
      unmask_event           <= unmask_next;
    end
  end

`ifndef SYNTHESIS
  a_rdy_cfs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(controller_status_reg[0] && controller_status_reg[1]))
    else $error("CSTS has RDY and CFS set together");

  a_doorbell_no_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && doorbell_valid) |-> (read_data == 64'h0 && !enable_attempt && !queue_reset))
    else $error("doorbell transfer carries register side effects");

  // an attempt ends in exactly one of RDY or CFS
  a_enable_not_reset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && enable_attempt) |-> (!queue_reset && (controller_ready != controller_fatal)))
    else $error("enable attempt reported with reset or without a verdict");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while pipeline can advance");
`endif

endmodule
